// File: design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// LFU block cache package
// Shared widths, command codes and the compare-unit result type.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int KEY_W   = 64;  // width of node_id and block_id
  localparam int PAY_W   = 64;  // width of the payload handle
  localparam int TOTAL_W = 32;  // width of the hit and miss totals
  localparam int CFG_W   = 5;   // width of the entries_in_use register
  localparam int SLOT_W  = 4;   // width of the slot result field

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_e;

  // Flags from the shared compare unit for the entry read in this cycle.
  typedef struct packed {
    logic key_match;
    logic cnt_less;
    logic cnt_equal;
  } cmp_res_t;

endpackage

// File: design/lbc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lbc_cmp.sv
// ----------------------------------------------------------------------------
// LFU block cache compare unit
// Compares the entry read this cycle against the request key and the
// running least use count.
// ----------------------------------------------------------------------------
module lbc_cmp #(
  parameter int CntW = 16
) (
  input  logic [lbc_pkg::KEY_W-1:0] rd_node_i,
  input  logic [lbc_pkg::KEY_W-1:0] rd_block_i,
  input  logic [lbc_pkg::KEY_W-1:0] key_node_i,
  input  logic [lbc_pkg::KEY_W-1:0] key_block_i,
  input  logic [CntW-1:0]           rd_cnt_i,
  input  logic [CntW-1:0]           least_i,
  output lbc_pkg::cmp_res_t         res_o
);

  import lbc_pkg::*;

  always_comb begin
    res_o.key_match = (rd_node_i == key_node_i) && (rd_block_i == key_block_i);
    res_o.cnt_less  = rd_cnt_i < least_i;
    res_o.cnt_equal = rd_cnt_i == least_i;
  end

endmodule

// File: design/lfu_block_cache_top.sv
// ----------------------------------------------------------------------------
// LFU block cache, top level
// Fully associative cache of (node_id, block_id) keys with payload handles
// and least-frequently-used replacement, walked one entry per cycle.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy then stays
// high until the result beat, which is shown for exactly one cycle with done_o
// high, and busy is already low in that cycle so the next command can be taken
// right away. The receiver cannot stall, so it must capture every result beat
// in the cycle it appears. The entries are walked one per cycle through the
// entry and count memories, with a single compare unit checking each entry as
// its read data returns. A lookup stops at the first valid entry whose key
// matches and then passes through a hit state that bumps its use count; a
// lookup that misses ends once the last active entry is checked. An insert
// into a free slot goes straight to the write, and an insert that replaces
// the least-used entry first walks all active entries. The active entry
// count resets to 16. Valid bits live in flip-flops that reset clears at
// once, so there is no clearing pass after reset. The active entry count is
// written through the configuration channel, which is always ready; write it
// only while no command is in flight. A value of 0 acts as 1 and a value
// above ENTRIES acts as ENTRIES.
// ----------------------------------------------------------------------------
module lfu_block_cache_top #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd_i,
  input  logic [lbc_pkg::KEY_W-1:0]   node_id_i,
  input  logic [lbc_pkg::KEY_W-1:0]   block_id_i,
  input  logic [lbc_pkg::PAY_W-1:0]   payload_in_i,
  // Result channel
  output logic                        done_o,
  output logic                        hit_o,
  output logic [lbc_pkg::SLOT_W-1:0]  slot_o,
  output logic [lbc_pkg::PAY_W-1:0]   payload_out_o,
  output logic [lbc_pkg::TOTAL_W-1:0] hits_total_o,
  output logic [lbc_pkg::TOTAL_W-1:0] misses_total_o,
  // Configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lbc_pkg::CFG_W-1:0]   cfg_data_i
);

  import lbc_pkg::*;

  // Index width addresses the entries; the counter width can also hold
  // ENTRIES itself, for the fill position and the active count.
  localparam int IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntrW = $clog2(ENTRIES + 1);
  localparam int NW    = (CntrW > CFG_W) ? CntrW : CFG_W;
  localparam int EntW  = 2 * KEY_W + PAY_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_WRITE
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     cfg_q, cfg_d;
  logic [CntrW-1:0]     n_q, n_d;
  logic [CntrW-1:0]     fp_q, fp_d;
  logic [CntrW-1:0]     rd_idx_q, rd_idx_d;
  logic                 pend_q, pend_d;
  logic [IdxW-1:0]      pend_idx_q, pend_idx_d;
  logic                 is_ins_q, is_ins_d;
  logic                 fill_q, fill_d;
  logic [KEY_W-1:0]     key_node_q, key_node_d;
  logic [KEY_W-1:0]     key_block_q, key_block_d;
  logic [PAY_W-1:0]     pay_in_q, pay_in_d;
  logic [IdxW-1:0]      slot_q, slot_d;
  logic [COUNT_BITS-1:0] least_q, least_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [PAY_W-1:0]     pay_hit_q, pay_hit_d;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [TOTAL_W-1:0]   hits_q, hits_d;
  logic [TOTAL_W-1:0]   miss_q, miss_d;
  logic                 done_q, done_d;
  logic                 hit_out_q, hit_out_d;
  logic [IdxW-1:0]      slot_out_q, slot_out_d;
  logic [PAY_W-1:0]     pay_out_q, pay_out_d;

  // Memory ports
  logic                  ent_we;
  logic [EntW-1:0]       ent_wdata;
  logic [EntW-1:0]       ent_rdata;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [IdxW-1:0]       raddr;

  logic [KEY_W-1:0]      rd_node;
  logic [KEY_W-1:0]      rd_block;
  logic [PAY_W-1:0]      rd_pay;
  cmp_res_t              cmp_res;

  logic [NW-1:0]         cfg_ext;
  logic [NW-1:0]         n_clamp;
  logic [CntrW-1:0]      n_act;
  logic                  scan_last;
  logic [IdxW+SLOT_W-1:0] slot_wide;

  // Clamp the register to the built range of entries.
  always_comb begin
    cfg_ext = NW'(cfg_q);
    if (cfg_ext == '0) begin
      n_clamp = NW'(1);
    end else if (cfg_ext > NW'(ENTRIES)) begin
      n_clamp = NW'(ENTRIES);
    end else begin
      n_clamp = cfg_ext;
    end
    n_act = n_clamp[CntrW-1:0];
  end

  assign raddr    = rd_idx_q[IdxW-1:0];
  assign rd_node  = ent_rdata[EntW-1 -: KEY_W];
  assign rd_block = ent_rdata[PAY_W +: KEY_W];
  assign rd_pay   = ent_rdata[PAY_W-1:0];
  assign ent_wdata = {key_node_q, key_block_q, pay_in_q};

  // The read data now being checked belongs to the last active entry.
  assign scan_last = rd_idx_q >= n_q;

  lbc_ram #(
    .Width (EntW),
    .Depth (ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (slot_q),
    .wdata_i (ent_wdata),
    .raddr_i (raddr),
    .rdata_o (ent_rdata)
  );

  lbc_ram #(
    .Width (COUNT_BITS),
    .Depth (ENTRIES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (slot_q),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  lbc_cmp #(
    .CntW (COUNT_BITS)
  ) u_cmp (
    .rd_node_i   (rd_node),
    .rd_block_i  (rd_block),
    .key_node_i  (key_node_q),
    .key_block_i (key_block_q),
    .rd_cnt_i    (cnt_rdata),
    .least_i     (least_q),
    .res_o       (cmp_res)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    n_d         = n_q;
    fp_d        = fp_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    is_ins_d    = is_ins_q;
    fill_d      = fill_q;
    key_node_d  = key_node_q;
    key_block_d = key_block_q;
    pay_in_d    = pay_in_q;
    slot_d      = slot_q;
    least_d     = least_q;
    cnt_d       = cnt_q;
    pay_hit_d   = pay_hit_q;
    valid_d     = valid_q;
    hits_d      = hits_q;
    miss_d      = miss_q;
    done_d      = 1'b0;
    hit_out_d   = hit_out_q;
    slot_out_d  = slot_out_q;
    pay_out_d   = pay_out_q;
    ent_we      = 1'b0;
    cnt_we      = 1'b0;
    cnt_wdata   = cnt_q;

    if (cfg_valid_i) begin
      cfg_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          key_node_d  = node_id_i;
          key_block_d = block_id_i;
          pay_in_d    = payload_in_i;
          is_ins_d    = cmd_e'(cmd_i) == CMD_INSERT;
          n_d         = n_act;
          rd_idx_d    = '0;
          pend_d      = 1'b0;
          if ((cmd_e'(cmd_i) == CMD_INSERT) && (fp_q < n_act)) begin
            fill_d  = 1'b1;
            slot_d  = fp_q[IdxW-1:0];
            fp_d    = fp_q + CntrW'(1);
            state_d = S_WRITE;
          end else begin
            fill_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous one is checked.
        if (rd_idx_q < n_q) begin
          rd_idx_d   = rd_idx_q + CntrW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[IdxW-1:0];
        end else begin
          pend_d = 1'b0;
        end

        if (pend_q) begin
          if (!is_ins_q) begin
            if (valid_q[pend_idx_q] && cmp_res.key_match) begin
              slot_d    = pend_idx_q;
              cnt_d     = cnt_rdata;
              pay_hit_d = rd_pay;
              pend_d    = 1'b0;
              state_d   = S_HIT;
            end else if (scan_last) begin
              if (miss_q != '1) begin
                miss_d = miss_q + TOTAL_W'(1);
              end
              done_d     = 1'b1;
              hit_out_d  = 1'b0;
              slot_out_d = '0;
              pay_out_d  = '0;
              state_d    = S_IDLE;
            end
          end else begin
            // Slot 0 keeps ties; elsewhere the later entry wins a tie.
            if ((pend_idx_q == '0) || cmp_res.cnt_less ||
                (cmp_res.cnt_equal && (slot_q != '0))) begin
              least_d = cnt_rdata;
              slot_d  = pend_idx_q;
            end
            if (scan_last) begin
              state_d = S_WRITE;
            end
          end
        end
      end

      S_HIT: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
        if (hits_q != '1) begin
          hits_d = hits_q + TOTAL_W'(1);
        end
        done_d     = 1'b1;
        hit_out_d  = 1'b1;
        slot_out_d = slot_q;
        pay_out_d  = pay_hit_q;
        state_d    = S_IDLE;
      end

      S_WRITE: begin
        ent_we          = 1'b1;
        cnt_we          = 1'b1;
        cnt_wdata       = fill_q ? '0 : COUNT_BITS'(1);
        valid_d[slot_q] = 1'b1;
        done_d          = 1'b1;
        hit_out_d       = 1'b0;
        slot_out_d      = slot_q;
        pay_out_d       = '0;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_RESET;
      n_q         <= '0;
      fp_q        <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      is_ins_q    <= 1'b0;
      fill_q      <= 1'b0;
      key_node_q  <= '0;
      key_block_q <= '0;
      pay_in_q    <= '0;
      slot_q      <= '0;
      least_q     <= '0;
      cnt_q       <= '0;
      pay_hit_q   <= '0;
      valid_q     <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      done_q      <= 1'b0;
      hit_out_q   <= 1'b0;
      slot_out_q  <= '0;
      pay_out_q   <= '0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      n_q         <= n_d;
      fp_q        <= fp_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      is_ins_q    <= is_ins_d;
      fill_q      <= fill_d;
      key_node_q  <= key_node_d;
      key_block_q <= key_block_d;
      pay_in_q    <= pay_in_d;
      slot_q      <= slot_d;
      least_q     <= least_d;
      cnt_q       <= cnt_d;
      pay_hit_q   <= pay_hit_d;
      valid_q     <= valid_d;
      hits_q      <= hits_d;
      miss_q      <= miss_d;
      done_q      <= done_d;
      hit_out_q   <= hit_out_d;
      slot_out_q  <= slot_out_d;
      pay_out_q   <= pay_out_d;
    end
  end

  // The slot field carries the low bits of the slot index.
  assign slot_wide = {{SLOT_W{1'b0}}, slot_out_q};

  assign busy           = state_q != S_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign hit_o          = hit_out_q;
  assign slot_o         = slot_wide[SLOT_W-1:0];
  assign payload_out_o  = pay_out_q;
  assign hits_total_o   = hits_q;
  assign misses_total_o = miss_q;

`ifndef NO_ASSERTIONS
  // A result beat is only shown once the sequencer is back in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat shown while busy");

  // An accepted command always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // A hit beat carries the payload captured from the matching entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hit_o && done_o |-> payload_out_o == pay_hit_q)
    else $error("hit payload does not match captured entry");

  // Miss and insert beats carry a zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && !hit_o) |-> (payload_out_o == '0))
    else $error("nonzero payload on miss or insert");

  // The hit total only moves on a hit beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (hits_total_o != $past(hits_total_o)) |-> (done_o && hit_o))
    else $error("hit total changed without a hit beat");
`endif

endmodule
